/* rtl/udci_pkg.sv */
// ============================================================================
// udci_pkg - shared definitions for the UART DAC command interpreter
// Byte codes, reset values, controller/datapath handshake types, helpers.
// ============================================================================
package udci_pkg;

    // Default history depth
    localparam int HISTORY_DEPTH_DEF = 16;

    // Reset values
    localparam logic [2:0]  WAVE_RESET = 3'd3;
    localparam logic [31:0] FREQ_RESET = 32'h0147_AE14;

    // Waveform codes
    localparam logic [2:0] WAVE_DC   = 3'd0;
    localparam logic [2:0] WAVE_RECT = 3'd1;
    localparam logic [2:0] WAVE_SAW  = 3'd2;
    localparam logic [2:0] WAVE_COS  = 3'd3;
    localparam logic [2:0] WAVE_ARB  = 3'd4;

    // Command characters
    localparam logic [7:0] CMD_DC     = 8'h44; // D
    localparam logic [7:0] CMD_RECT   = 8'h52; // R
    localparam logic [7:0] CMD_SAW    = 8'h53; // S
    localparam logic [7:0] CMD_COS    = 8'h43; // C
    localparam logic [7:0] CMD_ARB    = 8'h41; // A
    localparam logic [7:0] CMD_INC    = 8'h2B; // +
    localparam logic [7:0] CMD_DEC    = 8'h2D; // -
    localparam logic [7:0] CMD_DOUBLE = 8'h2A; // *
    localparam logic [7:0] CMD_HALVE  = 8'h2F; // /
    localparam logic [7:0] CMD_LEVEL  = 8'h2E; // .
    localparam logic [7:0] CMD_FREQ   = 8'h2C; // ,
    localparam logic [7:0] CMD_SPI    = 8'h3B; // ;

    // Frequency bounds and SPI read flag
    localparam logic [31:0] FREQ_INC_LIMIT    = 32'h0001_0000;
    localparam logic [31:0] FREQ_DOUBLE_LIMIT = 32'h0000_8000;
    localparam logic [15:0] SPI_READ_FLAG     = 16'h8000;

    // Digits popped per command
    localparam logic [2:0] POPS_LEVEL = 3'd3;
    localparam logic [2:0] POPS_FREQ  = 3'd4;
    localparam logic [2:0] POPS_SPI   = 3'd4;
    localparam logic [2:0] POPS_NONE  = 3'd0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUT,
        S_WAIT,
        S_TAKE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;    // capture accepted byte
        logic put;     // push byte into history ring
        logic take;    // pop one hex digit
        logic finish;  // execute command, load result
    } t_dp_cmd;

    typedef struct packed {
        logic [2:0] pop_cnt;  // digits the held byte needs
    } t_dp_status;

    function automatic logic [3:0] hex_digit(input logic [7:0] c);
        logic [3:0] d;
        d = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = c[3:0];
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            d = 4'(c[3:0] + 4'd9);
        end
        return d;
    endfunction

    function automatic logic [2:0] pop_count(input logic [7:0] c);
        logic [2:0] n;
        unique case (c)
            CMD_LEVEL: n = POPS_LEVEL;
            CMD_FREQ:  n = POPS_FREQ;
            CMD_SPI:   n = POPS_SPI;
            default:   n = POPS_NONE;
        endcase
        return n;
    endfunction

endpackage

/* rtl/udci_ctrl.sv */
// ============================================================================
// udci_ctrl - sequencing controller
// Walks each byte through ring push, digit pops and command execution;
// owns the result valid flag.
// ============================================================================
module udci_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_rx_valid,
    output logic                  o_rx_stall,
    output logic                  o_res_valid,
    input  logic                  i_res_stall,
    input  udci_pkg::t_dp_status  i_status,
    output udci_pkg::t_dp_cmd     o_cmd
);
    import udci_pkg::*;

    t_state     r_state, n_state;
    logic [2:0] r_pops, n_pops;
    logic       r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pops      <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pops      <= n_pops;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_pops      = r_pops;
        o_cmd       = '0;
        o_rx_stall  = (r_state != S_IDLE);
        n_out_valid = r_out_valid && i_res_stall;
        unique case (r_state)
            S_IDLE: begin
                if (i_rx_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_PUT;
                end
            end
            S_PUT: begin
                o_cmd.put = 1'b1;
                n_pops    = i_status.pop_cnt;
                n_state   = (i_status.pop_cnt == 3'd0) ? S_DONE : S_WAIT;
            end
            S_WAIT: begin
                // read data of the ring head settles
                n_state = S_TAKE;
            end
            S_TAKE: begin
                o_cmd.take = 1'b1;
                n_pops     = r_pops - 3'd1;
                n_state    = (r_pops == 3'd1) ? S_DONE : S_WAIT;
            end
            S_DONE: begin
                if (!r_out_valid || !i_res_stall) begin
                    o_cmd.finish = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_res_valid = r_out_valid;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> !(r_out_valid && i_res_stall))
        else $error("result overwritten while stalled");

    a_pops_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WAIT || r_state == S_TAKE) |-> (r_pops != 3'd0))
        else $error("digit pop without pending count");

endmodule

/* rtl/udci_dpath.sv */
// ============================================================================
// udci_dpath - history ring, digit accumulator and setting registers
// One write and one registered read port on the ring memory.
// ============================================================================
module udci_dpath #(
    parameter int HISTORY_DEPTH = udci_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [7:0]            i_rx_byte,
    input  udci_pkg::t_dp_cmd     i_cmd,
    output udci_pkg::t_dp_status  o_status,
    output logic [2:0]            o_waveform_sel,
    output logic [31:0]           o_freq_word,
    output logic [11:0]           o_dc_level,
    output logic                  o_settings_update,
    output logic                  o_spi_request,
    output logic [15:0]           o_spi_write_word,
    output logic [15:0]           o_spi_read_word,
    output logic                  o_report_status
);
    import udci_pkg::*;

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int CW = $clog2(HISTORY_DEPTH + 1);

    logic [7:0]    r_mem [HISTORY_DEPTH];
    logic [7:0]    r_rd_data;
    logic [7:0]    r_byte;
    logic [15:0]   r_acc;
    logic [AW-1:0] r_head, r_tail;
    logic [CW-1:0] r_count;
    logic [2:0]    r_wave;
    logic [31:0]   r_freq;
    logic [11:0]   r_level;
    logic          r_last_cmd;
    logic          r_upd, r_spi, r_rep;
    logic [15:0]   r_wr_word, r_rd_word;

    logic [AW-1:0] head_inc, tail_inc, wr_idx;
    logic          ring_full, ring_empty;
    logic [3:0]    digit;

    // Command execution results
    logic [2:0]  n_wave;
    logic [31:0] n_freq;
    logic [11:0] n_level;
    logic        n_last_cmd, n_upd, n_spi;

    assign head_inc   = (r_head == AW'(HISTORY_DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign tail_inc   = (r_tail == AW'(HISTORY_DEPTH - 1)) ? '0 : r_tail + 1'b1;
    assign ring_full  = (r_count == CW'(HISTORY_DEPTH));
    assign ring_empty = (r_count == '0);
    assign wr_idx     = ring_empty ? '0 : tail_inc;
    assign digit      = ring_empty ? 4'd0 : hex_digit(r_rd_data);

    // Ring memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.put) begin
            r_mem[wr_idx] <= r_byte;
        end
        r_rd_data <= r_mem[r_head];
    end

    always_comb begin
        n_wave     = r_wave;
        n_freq     = r_freq;
        n_level    = r_level;
        n_last_cmd = 1'b1;
        n_upd      = 1'b0;
        n_spi      = 1'b0;
        unique case (r_byte)
            CMD_DC:   begin n_wave = WAVE_DC;   n_upd = 1'b1; end
            CMD_RECT: begin n_wave = WAVE_RECT; n_upd = 1'b1; end
            CMD_SAW:  begin n_wave = WAVE_SAW;  n_upd = 1'b1; end
            CMD_COS:  begin n_wave = WAVE_COS;  n_upd = 1'b1; end
            CMD_ARB:  begin n_wave = WAVE_ARB;  n_upd = 1'b1; end
            CMD_INC: begin
                if (r_freq < FREQ_INC_LIMIT) begin
                    n_freq = r_freq + 32'd1;
                    n_upd  = 1'b1;
                end
            end
            CMD_DOUBLE: begin
                if (r_freq < FREQ_DOUBLE_LIMIT) begin
                    n_freq = {r_freq[30:0], 1'b0};
                    n_upd  = 1'b1;
                end
            end
            CMD_DEC: begin
                if (r_freq != 32'd0) begin
                    n_freq = r_freq - 32'd1;
                    n_upd  = 1'b1;
                end
            end
            CMD_HALVE: begin
                if (r_freq != 32'd0) begin
                    n_freq = {1'b0, r_freq[31:1]};
                    n_upd  = 1'b1;
                end
            end
            CMD_LEVEL: begin
                n_level = r_acc[11:0];
                n_upd   = 1'b1;
            end
            CMD_FREQ: begin
                n_freq = {16'd0, r_acc};
                n_upd  = 1'b1;
            end
            CMD_SPI: begin
                n_spi      = 1'b1;
                n_last_cmd = r_last_cmd;
            end
            default: n_last_cmd = 1'b0;
        endcase
    end

    // Byte capture, digit accumulator, result payload (no reset needed)
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_byte <= i_rx_byte;
            r_acc  <= 16'd0;
        end
        if (i_cmd.take) begin
            r_acc <= {r_acc[11:0], digit};
        end
        if (i_cmd.finish) begin
            r_upd     <= n_upd;
            r_spi     <= n_spi;
            r_rep     <= n_last_cmd;
            r_wr_word <= n_spi ? r_acc : 16'd0;
            r_rd_word <= n_spi ? (SPI_READ_FLAG | {r_acc[15:8], 8'h00}) : 16'd0;
        end
    end

    // Ring pointers and settings
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head     <= '0;
            r_tail     <= '0;
            r_count    <= '0;
            r_wave     <= WAVE_RESET;
            r_freq     <= FREQ_RESET;
            r_level    <= 12'd0;
            r_last_cmd <= 1'b0;
        end else begin
            if (i_cmd.put) begin
                if (ring_full) begin
                    // drop oldest, append newest
                    r_head <= head_inc;
                    r_tail <= tail_inc;
                end else if (ring_empty) begin
                    r_head  <= '0;
                    r_tail  <= '0;
                    r_count <= CW'(1);
                end else begin
                    r_tail  <= tail_inc;
                    r_count <= r_count + 1'b1;
                end
            end
            if (i_cmd.take && !ring_empty) begin
                r_count <= r_count - 1'b1;
                if (r_count == CW'(1)) begin
                    r_head <= '0;
                    r_tail <= '0;
                end else begin
                    r_head <= head_inc;
                end
            end
            if (i_cmd.finish) begin
                r_wave     <= n_wave;
                r_freq     <= n_freq;
                r_level    <= n_level;
                r_last_cmd <= n_last_cmd;
                if (n_last_cmd) begin
                    r_head  <= '0;
                    r_tail  <= '0;
                    r_count <= '0;
                end
            end
        end
    end

    assign o_status.pop_cnt  = pop_count(r_byte);
    assign o_waveform_sel    = r_wave;
    assign o_freq_word       = r_freq;
    assign o_dc_level        = r_level;
    assign o_settings_update = r_upd;
    assign o_spi_request     = r_spi;
    assign o_spi_write_word  = r_wr_word;
    assign o_spi_read_word   = r_rd_word;
    assign o_report_status   = r_rep;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(HISTORY_DEPTH))
        else $error("ring count above depth");

    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_head == '0 && r_tail == '0))
        else $error("empty ring with stray pointers");

endmodule

/* rtl/uart_dac_command_interpreter_core.sv */
// ============================================================================
// uart_dac_command_interpreter_core - UART command interpreter for a DAC
// Top level: controller plus datapath; one result per received byte.
// ============================================================================
// Each received byte yields exactly one result transfer. P is the number of
// hex digits the command pops: P = 0 for most bytes, 3 for '.', 4 for ','
// and ';'. Each pop waits on the single read port of the history memory: it
// issues a registered read of the ring head and then consumes it. The input
// stalls while a byte is in work, so one byte is taken at a time; a finished
// result sits in the output register and the next byte is taken while it
// waits, and a new result is only loaded once the old one has gone, so a
// stalled result can hold the next byte at its execute step.
// waveform_sel, freq_word and dc_level show the settings after the byte;
// settings_update, spi_request, the SPI words and report_status are per-byte
// flags. The history memory has no reset; the ring pointers empty it.
// ============================================================================
module uart_dac_command_interpreter_core #(
    parameter int HISTORY_DEPTH = udci_pkg::HISTORY_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // received byte channel
    input  logic        i_rx_valid,
    output logic        o_rx_stall,
    input  logic [7:0]  i_rx_byte,
    // result channel
    output logic        o_res_valid,
    input  logic        i_res_stall,
    output logic [2:0]  o_waveform_sel,
    output logic [31:0] o_freq_word,
    output logic [11:0] o_dc_level,
    output logic        o_settings_update,
    output logic        o_spi_request,
    output logic [15:0] o_spi_write_word,
    output logic [15:0] o_spi_read_word,
    output logic        o_report_status
);
    import udci_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    // Sequencer: push, pops, execute, result hand-off
    udci_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx_valid  (i_rx_valid),
        .o_rx_stall  (o_rx_stall),
        .o_res_valid (o_res_valid),
        .i_res_stall (i_res_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // History ring, digit assembly and settings registers
    udci_dpath #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_rx_byte         (i_rx_byte),
        .i_cmd             (cmd),
        .o_status          (status),
        .o_waveform_sel    (o_waveform_sel),
        .o_freq_word       (o_freq_word),
        .o_dc_level        (o_dc_level),
        .o_settings_update (o_settings_update),
        .o_spi_request     (o_spi_request),
        .o_spi_write_word  (o_spi_write_word),
        .o_spi_read_word   (o_spi_read_word),
        .o_report_status   (o_report_status)
    );

endmodule
